[hw/rtl/lsrg_pkg.sv]
package lsrg_pkg;

  localparam int unsigned RESULT_CAP = 32;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RGBA     = 3'd6;

  typedef struct packed {
    logic signed [16:0] shift_x;
    logic signed [16:0] shift_y;
    logic [15:0]        blur;
    logic [15:0]        spread;
    logic [15:0]        corner;
    logic [5:0]         layers;
    logic [31:0]        rgba;
  } cfg_t;

  // One rectangle, ready for layer stepping.
  typedef struct packed {
    logic signed [20:0] bx;    // rect_x + shift_x
    logic signed [20:0] by;
    logic [18:0]        rw;
    logic [18:0]        rh;
    logic [16:0]        e0;    // expansion of the outermost layer
    logic [5:0]         re0;   // remainder matching e0
    logic [15:0]        qb;    // blur / L
    logic [5:0]         rb;    // blur % L
    logic [8:0]         qa;    // 2a / N
    logic [10:0]        ra;    // 2a % N
    logic [10:0]        norm;  // N = L*(L+1)
    logic [5:0]         cnt;   // L
  } qent_t;

endpackage

[hw/rtl/lsrg_div.sv]
module lsrg_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;
  logic          fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q, num_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CW'(NW);
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      num_d = {num_q[NW-2:0], fits};
      rem_d = fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/lsrg_queue.sv]
module lsrg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lsrg_pkg::qent_t wdata_i,
  input  logic          pop_i,
  output lsrg_pkg::qent_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import lsrg_pkg::*;

  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  qent_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/lsrg_front.sv]
module lsrg_front #(
  parameter int unsigned MAX_LAYERS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsrg_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] rect_x_i,
  input  logic signed [19:0] rect_y_i,
  input  logic [18:0]        rect_width_i,
  input  logic [18:0]        rect_height_i,
  output logic               push_o,
  output lsrg_pkg::qent_t    ent_o,
  input  logic               full_i
);
  import lsrg_pkg::*;

  localparam int unsigned LCAP = (MAX_LAYERS < RESULT_CAP) ? MAX_LAYERS : RESULT_CAP;

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic signed [20:0] bx_q, by_q;
  logic [18:0]        rw_q, rh_q;
  logic [5:0]         cnt_q;
  logic [10:0]        norm_q;

  logic [5:0]  l_eff;
  logic [10:0] norm;
  logic        accept, useful, start;
  logic        busy_b, busy_a;
  logic [15:0] qb;
  logic [5:0]  rb;
  logic [8:0]  qa;
  logic [10:0] ra;

  assign l_eff  = (cfg_i.layers > 6'(LCAP)) ? 6'(LCAP) : cfg_i.layers;
  assign norm   = {5'd0, l_eff} * {5'd0, l_eff + 6'd1};
  assign accept = in_valid_i && (state_q == FS_IDLE);
  // Transparent color or no layers: the transaction is taken and dropped.
  assign useful = (cfg_i.rgba[7:0] != 8'd0) && (l_eff != 6'd0);
  assign start  = accept && useful;

  assign in_stall_o = state_q != FS_IDLE;

  lsrg_div #(.NW(16), .DW(6)) u_div_blur (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (cfg_i.blur),
    .den_i  (l_eff),
    .busy_o (busy_b),
    .quot_o (qb),
    .rem_o  (rb)
  );

  lsrg_div #(.NW(9), .DW(11)) u_div_alpha (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  ({cfg_i.rgba[7:0], 1'b0}),
    .den_i  (norm),
    .busy_o (busy_a),
    .quot_o (qa),
    .rem_o  (ra)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (start) state_d = FS_DIV;
      end
      FS_DIV: begin
        if (!busy_b && !busy_a) state_d = FS_PUSH;
      end
      FS_PUSH: begin
        if (!full_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      bx_q   <= 21'(rect_x_i) + 21'(cfg_i.shift_x);
      by_q   <= 21'(rect_y_i) + 21'(cfg_i.shift_y);
      rw_q   <= rect_width_i;
      rh_q   <= rect_height_i;
      cnt_q  <= l_eff;
      norm_q <= norm;
    end
  end

  // Outermost layer: spread + blur*(L-1)/L, using blur*(L-1) = (blur - qb)*L - rb.
  always_comb begin
    ent_o      = '0;
    ent_o.bx   = bx_q;
    ent_o.by   = by_q;
    ent_o.rw   = rw_q;
    ent_o.rh   = rh_q;
    ent_o.e0   = {1'b0, cfg_i.spread} + {1'b0, cfg_i.blur} - {1'b0, qb}
                 - {16'd0, (rb != 6'd0)};
    ent_o.re0  = (rb != 6'd0) ? cnt_q - rb : 6'd0;
    ent_o.qb   = qb;
    ent_o.rb   = rb;
    ent_o.qa   = qa;
    ent_o.ra   = ra;
    ent_o.norm = norm_q;
    ent_o.cnt  = cnt_q;
  end

  assign push_o = (state_q == FS_PUSH) && !full_i;

endmodule

[hw/rtl/lsrg_back.sv]
module lsrg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsrg_pkg::cfg_t     cfg_i,
  input  lsrg_pkg::qent_t    ent_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [19:0] layer_x_o,
  output logic signed [19:0] layer_y_o,
  output logic [18:0]        layer_width_o,
  output logic [18:0]        layer_height_o,
  output logic [17:0]        layer_radius_o,
  output logic [31:0]        layer_rgba_o,
  output logic               last_layer_o
);
  import lsrg_pkg::*;

  localparam logic signed [21:0] S20_MAX = 22'sd524287;
  localparam logic signed [21:0] S20_MIN = -22'sd524288;

  logic        busy_q;
  qent_t       ent_q;
  logic [5:0]  i_q;
  logic [16:0] e_q;
  logic [5:0]  re_q;
  logic [8:0]  qa_q;
  logic [10:0] ra_q;

  logic        out_valid_q;
  logic signed [19:0] x_q, y_q;
  logic [18:0] w_q, h_q;
  logic [17:0] corner_q;
  logic [31:0] rgba_q;
  logic        last_q;

  logic        emit, load, last;
  logic        re_lt, ge;
  logic [5:0]  re_nx;
  logic [16:0] e_nx;
  logic [11:0] ra_sum;
  logic [10:0] ra_nx;
  logic [8:0]  qa_nx;
  logic signed [21:0] lx_w, ly_w;
  logic [19:0] w_w, h_w;
  logic signed [19:0] lx_s, ly_s;

  assign emit  = busy_q && (!out_valid_q || !out_stall_i);
  assign load  = !busy_q && !empty_i;
  assign pop_o = load;
  assign last  = i_q == ent_q.cnt - 6'd1;

  // Step the expansion down by blur/L, borrowing from the remainder.
  assign re_lt = re_q < ent_q.rb;
  assign re_nx = re_lt ? re_q + ent_q.cnt - ent_q.rb : re_q - ent_q.rb;
  assign e_nx  = e_q - {1'b0, ent_q.qb} - {16'd0, re_lt};

  // Step alpha up by 2a/N, carrying from the remainder.
  assign ra_sum = {1'b0, ra_q} + {1'b0, ent_q.ra};
  assign ge     = ra_sum >= {1'b0, ent_q.norm};
  assign ra_nx  = ge ? 11'(ra_sum - {1'b0, ent_q.norm}) : ra_sum[10:0];
  assign qa_nx  = qa_q + ent_q.qa + {8'd0, ge};

  assign lx_w = 22'(ent_q.bx) - $signed({5'd0, e_q});
  assign ly_w = 22'(ent_q.by) - $signed({5'd0, e_q});
  assign w_w  = {1'b0, ent_q.rw} + {2'd0, e_q, 1'b0};
  assign h_w  = {1'b0, ent_q.rh} + {2'd0, e_q, 1'b0};

  always_comb begin
    if (lx_w > S20_MAX)      lx_s = S20_MAX[19:0];
    else if (lx_w < S20_MIN) lx_s = S20_MIN[19:0];
    else                     lx_s = lx_w[19:0];
    if (ly_w > S20_MAX)      ly_s = S20_MAX[19:0];
    else if (ly_w < S20_MIN) ly_s = S20_MIN[19:0];
    else                     ly_s = ly_w[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= ent_i;
      i_q   <= '0;
      e_q   <= ent_i.e0;
      re_q  <= ent_i.re0;
      qa_q  <= ent_i.qa;
      ra_q  <= ent_i.ra;
    end else if (emit) begin
      i_q   <= i_q + 6'd1;
      e_q   <= e_nx;
      re_q  <= re_nx;
      qa_q  <= qa_nx;
      ra_q  <= ra_nx;
    end
    if (emit) begin
      x_q      <= lx_s;
      y_q      <= ly_s;
      w_q      <= w_w[19] ? 19'h7FFFF : w_w[18:0];
      h_q      <= h_w[19] ? 19'h7FFFF : h_w[18:0];
      corner_q <= {2'd0, cfg_i.corner} + {1'b0, e_q};
      rgba_q   <= {cfg_i.rgba[31:8], qa_q[7:0]};
      last_q   <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign layer_x_o      = x_q;
  assign layer_y_o      = y_q;
  assign layer_width_o  = w_q;
  assign layer_height_o = h_q;
  assign layer_radius_o = corner_q;
  assign layer_rgba_o   = rgba_q;
  assign last_layer_o   = last_q;

endmodule

[hw/rtl/layered_shadow_rect_generator.sv]
// Layered drop-shadow generator: each accepted rectangle yields L shadow layers
// (L = layer_count, capped at MAX_LAYERS and at 32), outermost first, with the
// final one flagged by last_layer_o. A rectangle is dropped without output when
// the shadow alpha byte or L is zero. The front end handles each rectangle with
// a 16-step serial division of blur by L; the back end then emits one layer per
// cycle while results are not stalled. A two-entry queue lets the front end work
// on the next rectangle while layers are still going out.
// Configuration must only be written while the block is idle.
module layered_shadow_rect_generator #(
  parameter int unsigned MAX_LAYERS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lsrg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lsrg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [19:0]                 rect_x_i,
  input  logic signed [19:0]                 rect_y_i,
  input  logic [18:0]                        rect_width_i,
  input  logic [18:0]                        rect_height_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [19:0]                 layer_x_o,
  output logic signed [19:0]                 layer_y_o,
  output logic [18:0]                        layer_width_o,
  output logic [18:0]                        layer_height_o,
  output logic [17:0]                        layer_radius_o,
  output logic [31:0]                        layer_rgba_o,
  output logic                               last_layer_o
);
  import lsrg_pkg::*;

  cfg_t  cfg_q;
  qent_t push_ent, pop_ent;
  logic  push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{layers: 6'd1, default: '0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SHIFT_X: cfg_q.shift_x <= $signed(cfg_data_i[16:0]);
        REG_SHIFT_Y: cfg_q.shift_y <= $signed(cfg_data_i[16:0]);
        REG_BLUR:    cfg_q.blur    <= cfg_data_i[15:0];
        REG_SPREAD:  cfg_q.spread  <= cfg_data_i[15:0];
        REG_CORNER:  cfg_q.corner  <= cfg_data_i[15:0];
        REG_LAYERS:  cfg_q.layers  <= cfg_data_i[5:0];
        REG_RGBA:    cfg_q.rgba    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsrg_front #(.MAX_LAYERS(MAX_LAYERS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .push_o       (push),
    .ent_o        (push_ent),
    .full_i       (full)
  );

  lsrg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_ent),
    .pop_i  (pop),
    .rdata_o(pop_ent),
    .full_o (full),
    .empty_o(empty)
  );

  lsrg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .ent_i         (pop_ent),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .layer_x_o     (layer_x_o),
    .layer_y_o     (layer_y_o),
    .layer_width_o (layer_width_o),
    .layer_height_o(layer_height_o),
    .layer_radius_o(layer_radius_o),
    .layer_rgba_o  (layer_rgba_o),
    .last_layer_o  (last_layer_o)
  );

endmodule
